@@ sv/hbpmd_pkg.sv @@
// shared types and constants of the h-bridge pwm motor driver
package hbpmd_pkg;

  localparam int unsigned DUTY_W      = 16;
  localparam int unsigned REG_W       = 16;
  localparam int unsigned ID_W        = 4;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned PIN_FIELD_W = 4;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [REG_W-1:0] PERIOD_RESET    = 16'd1000;
  localparam logic [REG_W-1:0] DEAD_ZONE_RESET = 16'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_STOP = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_PWM  = 2'd2
  } mode_e;

  typedef enum logic {
    REG_PERIOD    = 1'b0,
    REG_DEAD_ZONE = 1'b1
  } reg_idx_e;

  // decoded request broadcast to every motor channel
  typedef struct packed {
    logic              tick;
    logic              set;
    logic              stop;
    logic              brake;
    logic              negative;
    logic [DUTY_W-1:0] mag;
  } motor_req_t;

endpackage

@@ sv/hbpmd_cmd_dec.sv @@
// input register and command decode: duty magnitude, dead zone, clamp, motor select
module hbpmd_cmd_dec #(
  parameter int unsigned MOTORS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hbpmd_pkg::CMD_W-1:0]    cmd_i,
  input  logic [hbpmd_pkg::ID_W-1:0]     motor_id_i,
  input  logic                           all_motors_i,
  input  logic [hbpmd_pkg::DUTY_W-1:0]   duty_i,
  input  logic                           brake_i,
  input  logic                           advance_i,
  input  logic [hbpmd_pkg::REG_W-1:0]    period_i,
  input  logic [hbpmd_pkg::REG_W-1:0]    dead_zone_i,
  output logic                           fire_o,
  output hbpmd_pkg::motor_req_t          req_o,
  output logic [MOTORS-1:0]              sel_o,
  output logic                           accepted_o
);
  import hbpmd_pkg::*;

  logic              valid_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   motor_id_q;
  logic              all_q;
  logic [DUTY_W-1:0] duty_q;
  logic              brake_q;

  logic              negative;
  logic [DUTY_W-1:0] raw_mag;
  logic [DUTY_W:0]   sum;
  logic [DUTY_W-1:0] clamped;
  logic              id_ok;
  logic              addressed;

  assign in_ready_o = !valid_q || advance_i;
  assign fire_o     = valid_q && advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q      <= cmd_i;
      motor_id_q <= motor_id_i;
      all_q      <= all_motors_i;
      duty_q     <= duty_i;
      brake_q    <= brake_i;
    end
  end

  // magnitude plus dead zone, clamped to the period; zero stays zero
  always_comb begin
    negative = duty_q[DUTY_W-1];
    raw_mag  = negative ? (~duty_q + DUTY_W'(1)) : duty_q;
    sum      = {1'b0, raw_mag} + {1'b0, dead_zone_i};
    clamped  = (sum > {1'b0, period_i}) ? period_i : sum[DUTY_W-1:0];
  end

  assign id_ok     = (motor_id_q >= ID_W'(1)) && (motor_id_q <= ID_W'(MOTORS));
  assign addressed = all_q || id_ok;

  always_comb begin
    for (int m = 0; m < MOTORS; m++) begin
      sel_o[m] = all_q || (motor_id_q == ID_W'(m + 1));
    end
  end

  always_comb begin
    req_o          = '0;
    req_o.brake    = brake_q;
    req_o.negative = negative;
    req_o.mag      = (raw_mag == '0) ? '0 : clamped;
    accepted_o     = 1'b0;
    case (cmd_q)
      CMD_SET: begin
        req_o.set  = addressed;
        accepted_o = addressed;
      end
      CMD_STOP: begin
        req_o.stop = addressed;
        accepted_o = addressed;
      end
      CMD_TICK: begin
        req_o.tick = 1'b1;
        accepted_o = 1'b1;
      end
      default: begin
        accepted_o = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/hbpmd_motor.sv @@
// one motor channel: counter, shadow and active compares, pin modes
module hbpmd_motor #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        sel_i,
  input  hbpmd_pkg::motor_req_t       req_i,
  input  logic [hbpmd_pkg::REG_W-1:0] period_i,
  output logic                        pin_a_o,
  output logic                        pin_b_o
);
  import hbpmd_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > DUTY_W) ? COUNT_WIDTH : DUTY_W;

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [DUTY_W-1:0]      shadow_a_q, shadow_a_d;
  logic [DUTY_W-1:0]      shadow_b_q, shadow_b_d;
  logic [DUTY_W-1:0]      active_a_q, active_a_d;
  logic [DUTY_W-1:0]      active_b_q, active_b_d;
  mode_e                  mode_a_q, mode_a_d;
  mode_e                  mode_b_q, mode_b_d;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] count_next;

  function automatic logic pin_level(mode_e mode, logic [COUNT_WIDTH-1:0] count,
                                     logic [DUTY_W-1:0] cmp);
    logic level;
    case (mode)
      MODE_LOW:  level = 1'b0;
      MODE_HIGH: level = 1'b1;
      default:   level = CMP_W'(count) < CMP_W'(cmp);
    endcase
    return level;
  endfunction

  // counter wraps at the period or on overflow
  always_comb begin
    count_inc  = count_q + COUNT_WIDTH'(1);
    count_next = (CMP_W'(count_inc) >= CMP_W'(period_i)) ? '0 : count_inc;
  end

  always_comb begin
    count_d    = count_q;
    shadow_a_d = shadow_a_q;
    shadow_b_d = shadow_b_q;
    active_a_d = active_a_q;
    active_b_d = active_b_q;
    mode_a_d   = mode_a_q;
    mode_b_d   = mode_b_q;
    if (fire_i && req_i.tick) begin
      count_d = count_next;
      if (count_next == '0) begin
        active_a_d = shadow_a_q;
        active_b_d = shadow_b_q;
      end
    end
    if (fire_i && sel_i && req_i.set) begin
      if (req_i.mag == '0) begin
        mode_a_d = MODE_LOW;
        mode_b_d = MODE_LOW;
      end else if (!req_i.negative) begin
        shadow_a_d = req_i.mag;
        mode_a_d   = MODE_PWM;
        mode_b_d   = MODE_LOW;
      end else begin
        shadow_b_d = req_i.mag;
        mode_a_d   = MODE_LOW;
        mode_b_d   = MODE_PWM;
      end
    end
    if (fire_i && sel_i && req_i.stop) begin
      mode_a_d = req_i.brake ? MODE_HIGH : MODE_LOW;
      mode_b_d = req_i.brake ? MODE_HIGH : MODE_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      shadow_a_q <= '0;
      shadow_b_q <= '0;
      active_a_q <= '0;
      active_b_q <= '0;
      mode_a_q   <= MODE_LOW;
      mode_b_q   <= MODE_LOW;
    end else begin
      count_q    <= count_d;
      shadow_a_q <= shadow_a_d;
      shadow_b_q <= shadow_b_d;
      active_a_q <= active_a_d;
      active_b_q <= active_b_d;
      mode_a_q   <= mode_a_d;
      mode_b_q   <= mode_b_d;
    end
  end

  // pin levels after this request's update
  assign pin_a_o = pin_level(mode_a_d, count_d, active_a_d);
  assign pin_b_o = pin_level(mode_b_d, count_d, active_b_d);

endmodule

@@ sv/h_bridge_pwm_motor_driver_core.sv @@
// top level of the multi-motor h-bridge pwm driver
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/s_axis_tready command requests
//   m_axis    out        m_axis_tvalid/m_axis_tready pin levels and accepted flag
//   cfg       in         cfg_we_i (no wait)          period and dead zone
//
// one request per cycle while m_axis is not stalled: the input
// register feeds decode, and the per-motor state registers update together
// with the result register
// reset: period 1000, dead zone 0, counters and compares 0, all pins low
// a stalled m_axis holds its result; one more request waits in the input
// register, then s_axis_tready drops
module h_bridge_pwm_motor_driver_core #(
  parameter int unsigned MOTORS      = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // motor_id[3:0], all_motors[4], duty[20:5], brake[21], zero pad[23:22]
  input  logic [hbpmd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command[1:0]
  input  logic [hbpmd_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pins_a[3:0], pins_b[7:4], accepted[8], zero pad[15:9]
  output logic [hbpmd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [hbpmd_pkg::REG_W-1:0]          cfg_data_i
);
  import hbpmd_pkg::*;

  logic [REG_W-1:0]       period_q;
  logic [REG_W-1:0]       dead_zone_q;
  logic                   advance;
  logic                   fire;
  motor_req_t             req;
  logic [MOTORS-1:0]      sel;
  logic                   accepted;
  logic [MOTORS-1:0]      pin_a;
  logic [MOTORS-1:0]      pin_b;
  logic [PIN_FIELD_W-1:0] pins_a_field;
  logic [PIN_FIELD_W-1:0] pins_b_field;
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      dead_zone_q <= DEAD_ZONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD:    period_q    <= cfg_data_i;
        REG_DEAD_ZONE: dead_zone_q <= cfg_data_i;
        default:       period_q    <= period_q;
      endcase
    end
  end

  // the pipe moves whenever the result register is free or being drained
  assign advance = !out_valid_q || m_axis_tready;

  hbpmd_cmd_dec #(
    .MOTORS (MOTORS)
  ) u_cmd_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .motor_id_i   (s_axis_tdata[3:0]),
    .all_motors_i (s_axis_tdata[4]),
    .duty_i       (s_axis_tdata[20:5]),
    .brake_i      (s_axis_tdata[21]),
    .advance_i    (advance),
    .period_i     (period_q),
    .dead_zone_i  (dead_zone_q),
    .fire_o       (fire),
    .req_o        (req),
    .sel_o        (sel),
    .accepted_o   (accepted)
  );

  for (genvar m = 0; m < MOTORS; m++) begin : g_motor
    hbpmd_motor #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_motor (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .fire_i   (fire),
      .sel_i    (sel[m]),
      .req_i    (req),
      .period_i (period_q),
      .pin_a_o  (pin_a[m]),
      .pin_b_o  (pin_b[m])
    );
  end

  // only the first four motors show in the pin fields
  always_comb begin
    pins_a_field = '0;
    pins_b_field = '0;
    for (int i = 0; i < PIN_FIELD_W; i++) begin
      if (i < MOTORS) begin
        pins_a_field[i] = pin_a[i];
        pins_b_field[i] = pin_b[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {7'd0, accepted, pins_b_field, pins_a_field};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ sv/hbpmd_checker.sv @@
// port-level checks for the h-bridge pwm motor driver, bound to the top level
module hbpmd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [hbpmd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import hbpmd_pkg::*;

  logic [7:0] last_pins_q;

  // pins of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_pins_q <= m_axis_tdata[7:0];
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a fresh result follows a request that passed the input register, then the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching request");

  // input backpressure only comes from a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while output empty");

  // a rejected request leaves every pin as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == last_pins_q)
    else $error("rejected request changed pins");

endmodule

bind h_bridge_pwm_motor_driver_core hbpmd_checker u_hbpmd_checker (.*);

@@ test/tb_checker.sv @@
`timescale 1ns / 1ps
// checker: predicts the motor pin levels and accepted flag of every request and compares them with each result
module tb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic                             s_ready_i,
  input  logic [hbpmd_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic [hbpmd_pkg::CMD_W-1:0]      s_user_i,
  input  logic                             m_valid_i,
  input  logic                             m_ready_i,
  input  logic [hbpmd_pkg::OUT_DATA_W-1:0] m_data_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [hbpmd_pkg::REG_W-1:0]      cfg_data_i,
  output int unsigned                      pending_o,
  output int unsigned                      errors_o
);
  import hbpmd_pkg::*;

  localparam int unsigned NUM_MOTORS = 4;

  // laid out as on m_axis_tdata, pins_a in the lowest bits
  typedef struct packed {
    logic                   accepted;
    logic [PIN_FIELD_W-1:0] pins_b;
    logic [PIN_FIELD_W-1:0] pins_a;
  } pin_result_t;

  logic [REG_W-1:0]  period_q;
  logic [REG_W-1:0]  dead_zone_q;
  logic [15:0]       count_q    [NUM_MOTORS];
  logic [15:0]       shadow_a_q [NUM_MOTORS];
  logic [15:0]       shadow_b_q [NUM_MOTORS];
  logic [15:0]       active_a_q [NUM_MOTORS];
  logic [15:0]       active_b_q [NUM_MOTORS];
  mode_e             mode_a_q   [NUM_MOTORS];
  mode_e             mode_b_q   [NUM_MOTORS];
  pin_result_t       expected_levels_q[$];
  int unsigned       n_req, n_res, n_err;

  assign pending_o = n_req - n_res;
  assign errors_o  = n_err;

  function automatic logic pin_level(mode_e mode, logic [15:0] cnt, logic [15:0] cmp);
    case (mode)
      MODE_LOW:  return 1'b0;
      MODE_HIGH: return 1'b1;
      default:   return cnt < cmp;
    endcase
  endfunction

  function automatic void set_duty(int m, logic [15:0] duty);
    logic        negative;
    int unsigned mag;
    negative = duty[15];
    mag = negative ? (32'h10000 - duty) : duty;
    if (mag != 0) begin
      mag += dead_zone_q;
      if (mag > period_q) mag = period_q;
    end
    if (mag == 0) begin
      mode_a_q[m] = MODE_LOW;
      mode_b_q[m] = MODE_LOW;
    end else if (!negative) begin
      shadow_a_q[m] = mag[15:0];
      mode_a_q[m]   = MODE_PWM;
      mode_b_q[m]   = MODE_LOW;
    end else begin
      shadow_b_q[m] = mag[15:0];
      mode_a_q[m]   = MODE_LOW;
      mode_b_q[m]   = MODE_PWM;
    end
  endfunction

  function automatic void tick_motor(int m);
    int unsigned nxt;
    nxt = (count_q[m] + 32'd1) & 32'hFFFF;
    if (nxt >= period_q) nxt = 0;
    count_q[m] = nxt[15:0];
    if (nxt == 0) begin
      active_a_q[m] = shadow_a_q[m];
      active_b_q[m] = shadow_b_q[m];
    end
  endfunction

  function automatic pin_result_t advance_bridges(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                  logic to_all, logic [15:0] duty, logic brake);
    pin_result_t r;
    int          first;
    int          last;
    r     = '0;
    first = 0;
    last  = -1;
    if (cmd == CMD_TICK) begin
      for (int m = 0; m < NUM_MOTORS; m++) tick_motor(m);
      r.accepted = 1'b1;
    end else if (cmd == CMD_SET || cmd == CMD_STOP) begin
      if (to_all) begin
        last = NUM_MOTORS - 1;
      end else if (id >= 1 && id <= NUM_MOTORS) begin
        first = id - 1;
        last  = first;
      end
      r.accepted = (last >= first);
      for (int m = first; m <= last; m++) begin
        if (cmd == CMD_SET) begin
          set_duty(m, duty);
        end else if (brake) begin
          mode_a_q[m] = MODE_HIGH;
          mode_b_q[m] = MODE_HIGH;
        end else begin
          mode_a_q[m] = MODE_LOW;
          mode_b_q[m] = MODE_LOW;
        end
      end
    end
    for (int m = 0; m < NUM_MOTORS; m++) begin
      r.pins_a[m] = pin_level(mode_a_q[m], count_q[m], active_a_q[m]);
      r.pins_b[m] = pin_level(mode_b_q[m], count_q[m], active_b_q[m]);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pin_result_t got;
    pin_result_t want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      period_q    = PERIOD_RESET;
      dead_zone_q = DEAD_ZONE_RESET;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        count_q[m]    = '0;
        shadow_a_q[m] = '0;
        shadow_b_q[m] = '0;
        active_a_q[m] = '0;
        active_b_q[m] = '0;
        mode_a_q[m]   = MODE_LOW;
        mode_b_q[m]   = MODE_LOW;
      end
      expected_levels_q.delete();
      n_req <= 0;
      n_res <= 0;
      n_err <= 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[$bits(pin_result_t)-1:0];
        n_res <= n_res + 1;
        if (expected_levels_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errs++;
        end else begin
          want = expected_levels_q.pop_front();
          if (got.pins_a !== want.pins_a) begin
            $display("%0t: pins_a expected %h actual %h", $time, want.pins_a, got.pins_a);
            errs++;
          end
          if (got.pins_b !== want.pins_b) begin
            $display("%0t: pins_b expected %h actual %h", $time, want.pins_b, got.pins_b);
            errs++;
          end
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                     got.accepted);
            errs++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        expected_levels_q.push_back(advance_bridges(s_user_i, s_data_i[3:0], s_data_i[4],
                                                    s_data_i[20:5], s_data_i[21]));
        n_req <= n_req + 1;
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_PERIOD:    period_q    = cfg_data_i;
          REG_DEAD_ZONE: dead_zone_q = cfg_data_i;
          default: ;
        endcase
      end
      n_err <= n_err + errs;
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus and verdict for the h-bridge pwm driver
module tb_top;
  import hbpmd_pkg::*;

  // command code the block has no use for
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SEG_REQS    = 112;
  localparam int unsigned NUM_SEGS    = 8;
  localparam int unsigned HOLD_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic                  cfg_idx;
  logic [REG_W-1:0]      cfg_data;

  int unsigned pending;
  int unsigned errors;

  // idle odds in percent, changed only while the block is idle
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // long receiver hold-off, requested by the stimulus and counted by the receiver
  logic        hold_req;
  int unsigned hold_left;

  int unsigned n_tick, n_set, n_stop, n_unused, n_settings;

  h_bridge_pwm_motor_driver_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  tb_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard limit far above the slowest correct run
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked for one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one request: optional idle cycles, then hold valid until taken
  task automatic send_req(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic to_all,
                          logic [DUTY_W-1:0] duty, logic brake);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, brake, duty, to_all, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (cmd)
      CMD_TICK: n_tick++;
      CMD_SET:  n_set++;
      CMD_STOP: n_stop++;
      default:  n_unused++;
    endcase
  endtask

  // drains the block, then writes one register
  task automatic write_reg(reg_idx_e idx, logic [REG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // every request gives a result, so a short pause covers the pipeline
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // random request, weighted toward ticks so the counters wrap often
  task automatic send_random();
    int unsigned       pick;
    int                d;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic              to_all;
    logic [DUTY_W-1:0] duty;
    pick = $urandom_range(99);
    if (pick < 55)      cmd = CMD_TICK;
    else if (pick < 80) cmd = CMD_SET;
    else if (pick < 95) cmd = CMD_STOP;
    else                cmd = CMD_UNUSED;
    // mostly valid motors, some broadcasts, the rest any id including invalid ones
    id     = ID_W'($urandom);
    to_all = 1'b0;
    pick   = $urandom_range(99);
    if (pick < 65)      id = ID_W'($urandom_range(1, 4));
    else if (pick < 80) to_all = 1'b1;
    else if (pick < 85) to_all = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      d    = int'($urandom_range(0, 40)) - 20;
      duty = d[DUTY_W-1:0];
    end else if (pick < 80) begin
      duty = DUTY_W'($urandom);
    end else begin
      case ($urandom_range(4))
        0:       duty = 16'h0000;
        1:       duty = 16'h0001;
        2:       duty = 16'hFFFF;
        3:       duty = 16'h7FFF;
        default: duty = 16'h8000;
      endcase
    end
    send_req(cmd, id, to_all, duty, 1'($urandom));
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_SET;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_PERIOD;
    cfg_data      <= '0;
    hold_req      <= 1'b0;
    rst_n         <= 1'b0;
    n_tick = 0; n_set = 0; n_stop = 0; n_unused = 0; n_settings = 0;
    // sender idles rarely, receiver often
    tx_idle_pct = 13;
    rx_idle_pct = 75;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, duty extremes, invalid ids, broadcast brake
    send_req(CMD_SET, 4'd1, 1'b0, 16'h7FFF, 1'b0);
    send_req(CMD_SET, 4'd2, 1'b0, 16'h8000, 1'b0);
    send_req(CMD_SET, 4'd3, 1'b0, 16'h0000, 1'b1);
    send_req(CMD_SET, 4'd4, 1'b0, 16'hFFFF, 1'b0);
    send_req(CMD_SET, 4'd0, 1'b0, 16'h0005, 1'b0);
    send_req(CMD_STOP, 4'd5, 1'b0, 16'h0000, 1'b1);
    send_req(CMD_STOP, 4'd15, 1'b1, 16'hFFFF, 1'b1);
    send_req(CMD_UNUSED, 4'hF, 1'b1, 16'hFFFF, 1'b1);
    send_req(CMD_STOP, 4'd2, 1'b0, 16'h0000, 1'b0);
    // short period of two: pins toggle every tick
    write_reg(REG_PERIOD, 16'd2);
    send_req(CMD_SET, 4'd0, 1'b1, 16'h0001, 1'b0);
    repeat (3) send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);
    send_req(CMD_SET, 4'd1, 1'b0, 16'hFFFE, 1'b0);
    repeat (2) send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);
    // zero period with the largest dead zone: any duty clamps to nothing
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_DEAD_ZONE, 16'hFFFF);
    send_req(CMD_SET, 4'd3, 1'b0, 16'h0007, 1'b0);
    send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);
    // period of one keeps the counter at zero
    write_reg(REG_PERIOD, 16'd1);
    send_req(CMD_SET, 4'd0, 1'b1, 16'hFFF7, 1'b0);
    repeat (2) send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);
    // largest period and dead zone together
    write_reg(REG_PERIOD, 16'hFFFF);
    send_req(CMD_SET, 4'd4, 1'b0, 16'h8000, 1'b0);
    send_req(CMD_SET, 4'd1, 1'b0, 16'h7FFF, 1'b0);
    send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);

    // run the counters high, then lower the period below them in the first segment
    write_reg(REG_PERIOD, 16'd300);
    write_reg(REG_DEAD_ZONE, 16'd0);
    send_req(CMD_SET, 4'd0, 1'b1, 16'd100, 1'b0);
    send_req(CMD_SET, 4'd2, 1'b0, -16'sd50, 1'b0);
    repeat (280) send_req(CMD_TICK, 4'd0, 1'b0, 16'h0000, 1'b0);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      logic [REG_W-1:0] per;
      logic [REG_W-1:0] dz;
      case (seg)
        0:       begin per = 16'd20;    dz = 16'd0;     end
        1:       begin per = 16'd5;     dz = 16'd3;     end
        2:       begin per = 16'd2;     dz = 16'd0;     end
        3:       begin per = 16'd13;    dz = 16'hFFFF;  end
        4:       begin per = 16'hFFFF;  dz = 16'd0;     end
        5:       begin per = 16'd7;     dz = 16'd1;     end
        6:       begin per = 16'd100;   dz = 16'd10;    end
        default: begin per = 16'd1000;  dz = 16'd0;     end
      endcase
      write_reg(REG_PERIOD, per);
      write_reg(REG_DEAD_ZONE, dz);
      // idle pattern: as above first, then swapped, then none at all
      if (seg == 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 13;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int i = 0; i < SEG_REQS; i++) begin
        // receiver holds off while requests keep coming, so the input side backs up
        if ((seg == 1 || seg == 4) && i == 20) begin
          s_axis_tvalid <= 1'b0;
          hold_req      <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        send_random();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests: %0d ticks, %0d sets, %0d stops, %0d unused commands",
             n_tick + n_set + n_stop + n_unused, n_tick, n_set, n_stop, n_unused);
    $display("%0d register settings, swapped idle patterns and two long receiver hold-offs",
             n_settings);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
